@@ rtl/bfwp_pkg.sv @@
// Package with shared types and constants for the bounded FIFO with peek.
`timescale 1ns / 1ps

package bfwp_pkg;

   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int FUNC_W     = 2;
   localparam int POS_W      = 16;
   localparam int CNT_W      = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]      CAP_RESET    = 11'd1024;
   localparam logic [CSR_ADDR_W-1:0] REG_CAPACITY = 2'd0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_STATUS = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic do_push;
      logic do_pop;
      logic do_read;
      logic fail;
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     at_cap;
      logic     is_zero;
      logic     pos_ok;
   } sts_type;

endpackage

@@ rtl/bfwp_ram.sv @@
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bfwp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/bfwp_ctrl.sv @@
// Controller state machine that sequences each FIFO transaction.
`timescale 1ns / 1ps

module bfwp_ctrl import bfwp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            busy = 1'b1;
            case (sts.func)
               FUNC_PUSH: begin
                  cmd.do_push = !sts.at_cap;
                  cmd.fail    = sts.at_cap;
               end
               FUNC_POP: begin
                  cmd.do_pop = !sts.is_zero;
                  cmd.fail   = sts.is_zero;
               end
               FUNC_QUERY: begin
                  cmd.do_read = sts.pos_ok;
                  cmd.fail    = !sts.pos_ok;
               end
               default: begin
                  cmd.fail = 1'b0;
               end
            endcase
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            cmd.capture = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_push, cmd.do_pop, cmd.do_read}))
      else $error("more than one datapath action in a cycle");

   a_exec_then_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff == ST_RESP)
      else $error("execution not followed by a response");

   a_action_needs_exec: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_push || cmd.do_pop || cmd.do_read || cmd.fail) |-> busy)
      else $error("datapath action outside the execute cycle");

endmodule

@@ rtl/bfwp_dp.sv @@
// Datapath with request registers, pointers, fill count and slot memory.
`timescale 1ns / 1ps

module bfwp_dp import bfwp_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output sts_type                      sts,
   input  logic                         clear,
   input  logic        [CNT_W-1:0]      capacity,
   input  logic        [FUNC_W-1:0]     req_func,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic        [POS_W-1:0]      req_position,
   output logic                         rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_data,
   output logic        [CNT_W-1:0]      rsp_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_MAX = (2 ** CNT_W) - 1;
   localparam int DEPTH_SAT = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;
   localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'(DEPTH_SAT);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

   func_type               func_ff;
   logic [DATA_WIDTH-1:0]  value_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   fail_ff;
   logic                   read_ok_ff;

   logic [CNT_W-1:0]       eff_cap;
   logic [POS_W-1:0]       pos_m1;
   logic [PTR_W:0]         idx_sum;
   logic [PTR_W-1:0]       rd_idx;
   logic [DATA_WIDTH-1:0]  rd_data;

   function automatic logic busy_cycle(input cmd_type c);
      return c.do_push | c.do_pop | c.do_read | c.fail | c.capture;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func_type'(req_func);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (busy_cycle(cmd)) begin
         fail_ff    <= cmd.fail;
         read_ok_ff <= cmd.do_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (cmd.do_push) begin
         tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (cmd.do_pop) begin
         head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   // Capacity above the memory depth saturates to the depth.
   assign eff_cap = (capacity > DEPTH_CAP) ? DEPTH_CAP : capacity;

   assign sts.func    = func_ff;
   assign sts.at_cap  = (count_ff >= eff_cap);
   assign sts.is_zero = (count_ff == '0);
   assign sts.pos_ok  = (pos_ff != '0) && (pos_ff <= POS_W'(count_ff));

   // The query offset is below the fill count, so one subtract wraps it.
   assign pos_m1  = pos_ff - 1'b1;
   assign idx_sum = {1'b0, head_ff} + {1'b0, pos_m1[PTR_W-1:0]};
   assign rd_idx  = (idx_sum >= DEPTH_EXT) ? PTR_W'(idx_sum - DEPTH_EXT)
                                           : idx_sum[PTR_W-1:0];

   bfwp_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (cmd.do_push),
      .wr_addr    (tail_ff),
      .wr_data    (value_ff),
      .rd_en      (cmd.do_read),
      .rd_addr    (rd_idx),
      .rd_data_ff (rd_data)
   );

   assign rsp_status   = fail_ff;
   assign rsp_data     = read_ok_ff ? signed'(rd_data) : '0;
   assign rsp_count    = count_ff;
   assign rsp_is_empty = (count_ff == '0);
   assign rsp_is_full  = (count_ff == eff_cap);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= eff_cap)
      else $error("fill count above capacity");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push && !clear |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not advance the fill count");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.do_read |-> (count_ff != '0))
      else $error("query read issued on an empty queue");

endmodule

@@ rtl/bounded_fifo_with_peek_top.sv @@
// Top level of the bounded FIFO with peek: register port and block wiring.
//
//   Channel   Ports                         Handshake
//   request   req_func/value/position       start high while busy low
//   result    rsp_status/data/count/flags   rsp_valid high for one cycle
//   config    psel/penable/pwrite/paddr...  write at access with pready
//
// A transaction has an execute step against the slot memory, which has a
// single read port with registered read data, and then a response step in
// which the result is shown. busy is high only in the execute cycle, so
// the next transaction is accepted while the previous result is shown.
// Reset is synchronous; it empties the queue and sets capacity to 1024.
// Results cannot be held off by the receiver.
`timescale 1ns / 1ps

module bounded_fifo_with_peek_top import bfwp_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic        [FUNC_W-1:0]     req_func,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic        [POS_W-1:0]      req_position,
   output logic                         rsp_valid,
   output logic                         rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_data,
   output logic        [CNT_W-1:0]      rsp_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic        [CSR_ADDR_W-1:0] paddr,
   input  logic        [CSR_DATA_W-1:0] pwdata,
   output logic        [CSR_DATA_W-1:0] prdata,
   output logic                         pready
);

   logic [CNT_W-1:0] capacity_ff, capacity_in;
   logic             cap_wr;
   cmd_type          cmd;
   sts_type          sts;

   assign pready = 1'b1;
   assign cap_wr = psel && penable && pwrite && (paddr == REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign capacity_in = cap_wr ? pwdata[CNT_W-1:0] : capacity_ff;
   assign prdata      = (paddr == REG_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   bfwp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   bfwp_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .clear        (cap_wr),
      .capacity     (capacity_ff),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full)
   );

   assign rsp_valid = cmd.respond;

endmodule
